>>> rtl/plt_pkg.sv
// Package with the shared types, constants and codes of the positional list table.
`timescale 1ns / 1ps
package plt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_BITS = 64;
   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int POS_BITS = 11;
   localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [2:0] {
      ACT_INSERT    = 3'd0,
      ACT_REMOVE    = 3'd1,
      ACT_FIND_NAME = 3'd2,
      ACT_FIND_ID   = 3'd3,
      ACT_COUNT     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [10:0] position;
      logic [63:0] id_key;
      logic [63:0] name_key;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [10:0] found_position;
      logic [63:0] found_id;
      logic [63:0] found_name;
      logic [10:0] record_count;
   } rsp_type;

   typedef struct packed {
      key_type id;
      key_type name;
   } rec_type;

   typedef struct packed {
      logic    hit;
      cnt_type pos;
      rec_type rec;
   } res_type;

   typedef struct packed {
      logic    shift_ins;
      logic    shift_rem;
      logic    step;
      logic    clear;
      logic    by_name;
      idx_type idx;
      cnt_type count;
      rec_type key;
   } cell_ctrl_type;

endpackage

>>> rtl/positional_list_table_unit.sv
// Top level of the positional list table: sequencer and the chain of record cells.
`timescale 1ns / 1ps
// A word is taken at a clock edge where start is high and busy is low, and its result
// word appears on rsp_word for exactly one cycle, marked by rsp_valid, in the cycle after
// the word was taken for insert, remove, count and unknown actions, and for a search of
// an empty table. Those actions keep busy low, so a new word may follow every cycle.
// A search holds busy high while the result walks the cell chain toward the head, one
// cell per cycle, through one chain step per stored record in the search state and then
// a finish state that registers the result word. The receiver cannot stall the result,
// and every result is strobed once.
module positional_list_table_unit
   import plt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_word,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   cell_ctrl_type cell_ctrl;
   rec_type       rec_chain [TABLE_DEPTH];
   res_type       res_chain [TABLE_DEPTH];

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .busy      (busy),
      .cell_ctrl (cell_ctrl),
      .head_res  (res_chain[0]),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;
      res_type right_res;

      if (g == 0) begin : g_head
         assign left_rec = '0;
      end else begin : g_body
         assign left_rec = rec_chain[g-1];
      end

      // The last cell has no neighbor: it keeps its record and sees no result behind it.
      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign right_rec = rec_chain[g];
         assign right_res = '0;
      end else begin : g_inner
         assign right_rec = rec_chain[g+1];
         assign right_res = res_chain[g+1];
      end

      plt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .index     (idx_type'(g)),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .right_res (right_res),
         .rec_out   (rec_chain[g]),
         .res_out   (res_chain[g])
      );
   end

endmodule

>>> rtl/plt_cell.sv
// One table cell: holds a record, shifts with its neighbors and forwards search results.
`timescale 1ns / 1ps
module plt_cell
   import plt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  idx_type       index,
   input  rec_type       left_rec,
   input  rec_type       right_rec,
   input  res_type       right_res,
   output rec_type       rec_out,
   output res_type       res_out
);

   rec_type rec_ff, rec_in;
   res_type res_ff, res_in;
   logic    live;
   logic    hit;

   always_comb begin
      live = cnt_type'(index) < ctrl.count;
      hit = ctrl.by_name ? (rec_ff.name == ctrl.key.name) : (rec_ff.id == ctrl.key.id);

      rec_in = rec_ff;
      if (ctrl.shift_ins) begin
         if (index > ctrl.idx) begin
            rec_in = left_rec;
         end else if (index == ctrl.idx) begin
            rec_in = ctrl.key;
         end
      end else if (ctrl.shift_rem) begin
         if (index >= ctrl.idx) begin
            rec_in = right_rec;
         end
      end

      // A hit here beats anything that arrives from further down the chain.
      res_in = res_ff;
      if (ctrl.clear) begin
         res_in.hit = 1'b0;
      end else if (ctrl.step) begin
         if (live && hit) begin
            res_in.hit = 1'b1;
            res_in.pos = cnt_type'(index) + cnt_type'(1);
            res_in.rec = rec_ff;
         end else begin
            res_in = right_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.hit <= 1'b0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign rec_out = rec_ff;
   assign res_out = res_ff;

endmodule

>>> rtl/plt_ctrl.sv
// Command sequencer: range checks, record count, search timing and the result register.
`timescale 1ns / 1ps
module plt_ctrl
   import plt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req_word,
   output logic          busy,
   output cell_ctrl_type cell_ctrl,
   input  res_type       head_res,
   output logic          rsp_valid,
   output rsp_type       rsp_word
);

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   cnt_type   remain_ff, remain_in;
   rec_type   key_ff, key_in;
   logic      by_name_ff, by_name_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   rec_type   req_key;
   logic [CMP_BITS-1:0] pos_cmp;
   logic [CMP_BITS-1:0] cnt_cmp;
   logic      ins_ok;
   logic      rem_ok;

   always_comb begin
      req_key.id = req_word.id_key[KEY_BITS-1:0];
      req_key.name = req_word.name_key[KEY_BITS-1:0];
      pos_cmp = CMP_BITS'(req_word.position);
      cnt_cmp = CMP_BITS'(count_ff);
      ins_ok = (pos_cmp != '0) && ((pos_cmp - CMP_BITS'(1)) <= cnt_cmp) &&
               (cnt_cmp < CMP_BITS'(TABLE_DEPTH));
      rem_ok = (pos_cmp != '0) && (pos_cmp <= cnt_cmp);

      state_in = state_ff;
      count_in = count_ff;
      remain_in = remain_ff;
      key_in = key_ff;
      by_name_in = by_name_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;

      cell_ctrl.shift_ins = 1'b0;
      cell_ctrl.shift_rem = 1'b0;
      cell_ctrl.step = 1'b0;
      cell_ctrl.clear = 1'b0;
      cell_ctrl.by_name = by_name_ff;
      cell_ctrl.idx = idx_type'(pos_cmp - CMP_BITS'(1));
      cell_ctrl.count = count_ff;
      cell_ctrl.key = (state_ff == ST_IDLE) ? req_key : key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.status = 1'b1;
               case (action_type'(req_word.action))
                  ACT_INSERT: begin
                     if (ins_ok) begin
                        cell_ctrl.shift_ins = 1'b1;
                        count_in = count_ff + cnt_type'(1);
                        rsp_in.status = 1'b0;
                     end
                  end
                  ACT_REMOVE: begin
                     if (rem_ok) begin
                        cell_ctrl.shift_rem = 1'b1;
                        count_in = count_ff - cnt_type'(1);
                        rsp_in.status = 1'b0;
                     end
                  end
                  ACT_FIND_NAME, ACT_FIND_ID: begin
                     key_in = req_key;
                     by_name_in = (action_type'(req_word.action) == ACT_FIND_NAME);
                     cell_ctrl.clear = 1'b1;
                     // An empty table misses at once; otherwise one chain step per record.
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        remain_in = count_ff;
                        state_in = ST_SEARCH;
                     end
                  end
                  ACT_COUNT: begin
                     rsp_in.status = 1'b0;
                  end
                  default: begin
                     rsp_in.status = 1'b1;
                  end
               endcase
               rsp_in.record_count = 11'(count_in);
            end
         end
         ST_SEARCH: begin
            cell_ctrl.step = 1'b1;
            remain_in = remain_ff - cnt_type'(1);
            if (remain_ff == cnt_type'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.status = !head_res.hit;
            rsp_in.record_count = 11'(count_ff);
            if (head_res.hit) begin
               rsp_in.found_position = 11'(head_res.pos);
               rsp_in.found_id = 64'(head_res.rec.id);
               rsp_in.found_name = 64'(head_res.rec.name);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         remain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         remain_ff <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      by_name_ff <= by_name_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule

>>> test/tb_positional_list_table_unit.sv
// Self-checking testbench of the positional list table: random and directed words against a predictor.
`timescale 1ns / 1ps
module tb_positional_list_table_unit;
   import plt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 32;
   localparam int POOL_SIZE = 6;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   // Predicted contents of the table, kept in step with every accepted word.
   key_type id_tab [TABLE_DEPTH];
   key_type name_tab [TABLE_DEPTH];
   int      rec_count = 0;

   rsp_type expected_rsp_q [$];
   rsp_type expected_rsp;
   key_type id_pool [POOL_SIZE];
   key_type name_pool [POOL_SIZE];
   int      fail_count = 0;
   int      quiet_cycles = 0;
   int      idle_pct = 0;

   positional_list_table_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] key_mask();
      return (KEY_BITS == 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);
   endfunction

   // Applies one word to the predicted table and returns the result it must produce.
   function automatic rsp_type predict_list_action(req_type w);
      rsp_type r;
      int      pos;
      logic    found;
      key_type idk;
      key_type nmk;
      r = '0;
      r.status = 1'b1;
      pos = w.position;
      found = 1'b0;
      idk = w.id_key & key_mask();
      nmk = w.name_key & key_mask();
      case (w.action)
         ACT_INSERT: begin
            if (pos >= 1 && pos <= rec_count + 1 && rec_count < TABLE_DEPTH) begin
               for (int k = rec_count; k >= pos; k--) begin
                  id_tab[k] = id_tab[k-1];
                  name_tab[k] = name_tab[k-1];
               end
               id_tab[pos-1] = idk;
               name_tab[pos-1] = nmk;
               rec_count++;
               r.status = 1'b0;
            end
         end
         ACT_REMOVE: begin
            if (pos >= 1 && pos <= rec_count) begin
               for (int k = pos - 1; k + 1 < rec_count; k++) begin
                  id_tab[k] = id_tab[k+1];
                  name_tab[k] = name_tab[k+1];
               end
               rec_count--;
               r.status = 1'b0;
            end
         end
         ACT_FIND_NAME, ACT_FIND_ID: begin
            for (int k = 0; k < rec_count; k++) begin
               if (!found && ((w.action == ACT_FIND_NAME) ? (name_tab[k] == nmk)
                                                           : (id_tab[k] == idk))) begin
                  found = 1'b1;
                  r.status = 1'b0;
                  r.found_position = 11'(k + 1);
                  r.found_id = 64'(id_tab[k]);
                  r.found_name = 64'(name_tab[k]);
               end
            end
         end
         ACT_COUNT: r.status = 1'b0;
         default: r.status = 1'b1;
      endcase
      r.record_count = 11'(rec_count);
      return r;
   endfunction

   function automatic req_type make_word(logic [2:0] act, int pos, logic [63:0] idk,
                                         logic [63:0] nmk);
      req_type w;
      w.action = act;
      w.position = 11'(pos);
      w.id_key = idk;
      w.name_key = nmk;
      return w;
   endfunction

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Half the keys come from a small pool so that searches hit and duplicates occur.
   function automatic logic [63:0] pick_id();
      return ($urandom_range(1) == 0) ? id_pool[$urandom_range(POOL_SIZE - 1)] : random_key();
   endfunction

   function automatic logic [63:0] pick_name();
      return ($urandom_range(1) == 0) ? name_pool[$urandom_range(POOL_SIZE - 1)] : random_key();
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic check_field(input string field, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
      if (got_val !== exp_val)
         report_mismatch($sformatf("%s expected %0h got %0h", field, exp_val, got_val));
   endtask

   // Holds one word on the request port until it is taken, then idles at random.
   task automatic send_word(input req_type w);
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_rsp_q.push_back(predict_list_action(w));
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic test_directed_cases();
      logic [63:0] ka;
      logic [63:0] kb;
      logic [63:0] kc;
      ka = 64'h0123_4567_89AB_CDEF;
      kb = 64'hFEDC_BA98_7654_3210;
      kc = 64'h5A5A_A5A5_0F0F_F0F0;
      send_word(make_word(ACT_COUNT, 0, '0, '0));
      send_word(make_word(ACT_FIND_NAME, 1, ka, kb));
      send_word(make_word(ACT_FIND_ID, 1, ka, kb));
      send_word(make_word(ACT_REMOVE, 1, '0, '0));
      send_word(make_word(ACT_REMOVE, 0, '0, '0));
      send_word(make_word(ACT_INSERT, 0, ka, kb));
      send_word(make_word(ACT_INSERT, 2, ka, kb));
      send_word(make_word(ACT_INSERT, 1, '0, '1));
      send_word(make_word(ACT_INSERT, 2, '1, '0));
      send_word(make_word(ACT_INSERT, 1, ka, kb));
      // A duplicate id in the middle: the search must report the first one.
      send_word(make_word(ACT_INSERT, 2, ka, kc));
      send_word(make_word(ACT_FIND_ID, 2047, ka, '1));
      send_word(make_word(ACT_FIND_NAME, 0, '1, '0));
      send_word(make_word(ACT_FIND_ID, 0, '1, kc));
      send_word(make_word(ACT_FIND_NAME, 0, ka, kb ^ 64'h1));
      send_word(make_word(3'd5, 2047, '1, '1));
      send_word(make_word(3'd6, 1, '1, '1));
      send_word(make_word(3'd7, 1024, '0, '0));
      send_word(make_word(ACT_REMOVE, 5, '0, '0));
      send_word(make_word(ACT_REMOVE, 4, '0, '0));
      send_word(make_word(ACT_REMOVE, 1, '0, '0));
      send_word(make_word(ACT_REMOVE, 2047, '0, '0));
      send_word(make_word(ACT_INSERT, 2047, kc, kc));
      send_word(make_word(ACT_COUNT, 1025, '1, '1));
   endtask

   task automatic test_random_ops(input int n_words);
      int roll;
      int cnt;
      int ins_weight;
      for (int i = 0; i < n_words; i++) begin
         roll = $urandom_range(99);
         cnt = rec_count;
         // Lean toward removals once the table grows, so searches stay short.
         ins_weight = (cnt > 40) ? 15 : 38;
         if (roll < ins_weight)
            send_word(make_word(ACT_INSERT, $urandom_range(cnt + 1, 1), pick_id(), pick_name()));
         else if (roll < ins_weight + 22)
            send_word(make_word(ACT_REMOVE, (cnt > 0) ? $urandom_range(cnt, 1) : 1,
                                random_key(), random_key()));
         else if (roll < ins_weight + 36)
            send_word(make_word(ACT_FIND_NAME, $urandom_range(2047), random_key(),
                                (cnt > 0 && $urandom_range(1) == 0)
                                   ? 64'(name_tab[$urandom_range(cnt - 1)]) : pick_name()));
         else if (roll < ins_weight + 50)
            send_word(make_word(ACT_FIND_ID, $urandom_range(2047),
                                (cnt > 0 && $urandom_range(1) == 0)
                                   ? 64'(id_tab[$urandom_range(cnt - 1)]) : pick_id(),
                                random_key()));
         else if (roll < ins_weight + 55)
            send_word(make_word(ACT_COUNT, $urandom_range(2047), random_key(), random_key()));
         else if (roll < ins_weight + 58)
            send_word(make_word($urandom_range(1) ? ACT_INSERT : ACT_REMOVE,
                                $urandom_range(1) ? cnt + 2 : cnt + 1,
                                pick_id(), pick_name()));
         else
            send_word(make_word(3'($urandom_range(7)), $urandom_range(2047),
                                random_key(), random_key()));
      end
   endtask

   task automatic test_full_table();
      while (rec_count < TABLE_DEPTH) begin
         send_word(make_word(ACT_INSERT,
                             ($urandom_range(3) == 0) ? $urandom_range(rec_count + 1, 1)
                                                       : rec_count + 1,
                             pick_id(), pick_name()));
         if ($urandom_range(63) == 0)
            send_word(make_word(ACT_FIND_ID, 0, id_tab[$urandom_range(rec_count - 1)], '0));
      end
      send_word(make_word(ACT_INSERT, TABLE_DEPTH + 1, random_key(), random_key()));
      send_word(make_word(ACT_INSERT, 1, random_key(), random_key()));
      send_word(make_word(ACT_FIND_NAME, 0, '0, name_tab[TABLE_DEPTH - 1]));
      send_word(make_word(ACT_FIND_ID, 0, 64'hDEAD_BEEF_0BAD_F00D, '0));
      send_word(make_word(ACT_COUNT, 0, '0, '0));
      send_word(make_word(ACT_REMOVE, TABLE_DEPTH + 1, '0, '0));
      send_word(make_word(ACT_REMOVE, TABLE_DEPTH, '0, '0));
      send_word(make_word(ACT_INSERT, 1, '1, '1));
      send_word(make_word(ACT_FIND_ID, 0, id_tab[TABLE_DEPTH - 1], '0));
      send_word(make_word(ACT_FIND_NAME, 0, '0, '1));
   endtask

   // Checks every result word against the oldest prediction and watches for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result word with no prediction waiting");
            end else begin
               expected_rsp = expected_rsp_q.pop_front();
               check_field("status", 64'(expected_rsp.status), 64'(rsp_word.status));
               check_field("found_position", 64'(expected_rsp.found_position),
                           64'(rsp_word.found_position));
               check_field("found_id", expected_rsp.found_id, rsp_word.found_id);
               check_field("found_name", expected_rsp.found_name, rsp_word.found_name);
               check_field("record_count", 64'(expected_rsp.record_count),
                           64'(rsp_word.record_count));
            end
         end
         if (rsp_valid || (start && !busy))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", expected_rsp_q.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         id_pool[i] = random_key();
         name_pool[i] = random_key();
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 14;
      test_directed_cases();
      test_random_ops(40);
      idle_pct = 48;
      test_random_ops(40);
      idle_pct = 0;
      test_random_ops(40);
      test_full_table();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/plt_pkg.sv
rtl/plt_cell.sv
rtl/plt_ctrl.sv
rtl/positional_list_table_unit.sv
test/tb_positional_list_table_unit.sv
